### design/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants of the serial command frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 32;

  localparam logic [7:0] CMD_TYPE     = 8'h80;
  localparam logic [7:0] MIN_LENGTH   = 8'd3;
  localparam logic [4:0] RESULT_LIMIT = 5'd26;

  localparam logic [7:0] HEADER_RST   = 8'hAA;
  localparam logic [7:0] TAIL_RST     = 8'h55;
  localparam logic [4:0] MAX_DATA_RST = 5'd26;

  typedef enum logic [1:0] {
    CFG_HEADER   = 2'd0,
    CFG_TAIL     = 2'd1,
    CFG_MAX_DATA = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] tail_byte;
    logic [4:0] max_data_bytes;
  } cfg_t;

  // completed command handed from front to back
  typedef struct packed {
    logic [7:0] address;
    logic [4:0] data_cnt;
    logic       bank;
  } desc_t;

  typedef struct packed {
    logic [7:0] cmd_address;
    logic [4:0] cmd_data_length;
    logic [4:0] byte_index;
    logic       no_data;
    logic       last;
  } res_info_t;

endpackage

### design/scfp_byte_if.sv
// ----------------------------------------------------------------------------
// scfp_byte_if
// Received byte channel: valid/ready handshake, one byte per word.
// ----------------------------------------------------------------------------
interface scfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

### design/scfp_cmd_if.sv
// ----------------------------------------------------------------------------
// scfp_cmd_if
// Command result channel: valid/ready handshake, one data byte per word.
// ----------------------------------------------------------------------------
interface scfp_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_address;
  logic [4:0] cmd_data_length;
  logic [4:0] byte_index;
  logic [7:0] cmd_data_byte;
  logic       last;

  modport source (output valid, output cmd_address, output cmd_data_length,
                  output byte_index, output cmd_data_byte, output last, input ready);
  modport sink   (input valid, input cmd_address, input cmd_data_length,
                  input byte_index, input cmd_data_byte, input last, output ready);
endinterface

### design/scfp_ram.sv
// ----------------------------------------------------------------------------
// scfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/scfp_front.sv
// ----------------------------------------------------------------------------
// scfp_front
// Collects frame bytes, keeps the running XOR, stores data bytes and
// pushes a descriptor for every frame that passes all checks.
// ----------------------------------------------------------------------------
module scfp_front import scfp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int unsigned IDX_W = $clog2(BUFFER_BYTES),
  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  scfp_byte_if.sink        in_i,
  input  logic             q_full_i,
  output logic             push_o,
  output desc_t            desc_o,
  output logic             mem_we_o,
  output logic [IDX_W:0]   mem_waddr_o,
  output logic [7:0]       mem_wdata_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic             bank_q, bank_d;
  logic [7:0]       hdr_q, hdr_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       cks_q, cks_d;

  logic             fire;
  logic [7:0]       b;
  logic [CNT_W:0]   cks_pos, tail_pos;
  logic [7:0]       data_len;
  logic [4:0]       limit;
  logic             len_bad;
  logic             frame_ok;

  assign in_i.ready = !q_full_i;
  assign fire       = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;

  assign cks_pos  = {1'b0, len_q} + (CNT_W+1)'(1);
  assign tail_pos = {1'b0, len_q} + (CNT_W+1)'(2);
  assign data_len = 8'(len_q) - MIN_LENGTH;
  assign limit    = (cfg_i.max_data_bytes > RESULT_LIMIT) ? RESULT_LIMIT
                                                          : cfg_i.max_data_bytes;
  assign len_bad  = (b < MIN_LENGTH) ||
                    (({1'b0, b} + {1'b0, MIN_LENGTH}) > 9'(BUFFER_BYTES));
  assign frame_ok = (hdr_q == cfg_i.header_byte) && (type_q == CMD_TYPE) &&
                    (cks_q == xor_q) && (b == cfg_i.tail_byte) &&
                    (data_len <= {3'b000, limit});

  always_comb begin
    cnt_d    = cnt_q;
    len_d    = len_q;
    bank_d   = bank_q;
    hdr_d    = hdr_q;
    type_d   = type_q;
    addr_d   = addr_q;
    xor_d    = xor_q;
    cks_d    = cks_q;
    push_o   = 1'b0;
    mem_we_o = 1'b0;
    if (fire) begin
      if (cnt_q == '0) begin
        if (b == cfg_i.header_byte) begin
          hdr_d = b;
          cnt_d = CNT_W'(1);
        end
      end else if (cnt_q == CNT_W'(1)) begin
        if (len_bad) begin
          cnt_d = '0;
        end else begin
          len_d = CNT_W'(b);
          xor_d = b;
          cnt_d = CNT_W'(2);
        end
      end else if ({1'b0, cnt_q} == tail_pos) begin
        push_o = frame_ok;
        cnt_d  = '0;
        if (frame_ok) begin
          bank_d = !bank_q;
        end
      end else if ({1'b0, cnt_q} == cks_pos) begin
        cks_d = b;
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        xor_d = xor_q ^ b;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(2)) begin
          type_d = b;
        end else if (cnt_q == CNT_W'(3)) begin
          addr_d = b;
        end else begin
          mem_we_o = 1'b1;
        end
      end
    end
  end

  assign mem_waddr_o = {bank_q, IDX_W'(cnt_q - CNT_W'(4))};
  assign mem_wdata_o = b;

  assign desc_o.address  = addr_q;
  assign desc_o.data_cnt = data_len[4:0];
  assign desc_o.bank     = bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      bank_q <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    hdr_q  <= hdr_d;
    type_q <= type_d;
    addr_q <= addr_d;
    xor_q  <= xor_d;
    cks_q  <= cks_d;
  end

endmodule

### design/scfp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// scfp_cmd_fifo
// Two-entry queue of command descriptors between front and back.
// ----------------------------------------------------------------------------
module scfp_cmd_fifo import scfp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output desc_t head_o
);

  desc_t      ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= desc_i;
    end
  end

endmodule

### design/scfp_back.sv
// ----------------------------------------------------------------------------
// scfp_back
// Walks the data bytes of each queued command and drives result words.
// ----------------------------------------------------------------------------
module scfp_back import scfp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int unsigned IDX_W = $clog2(BUFFER_BYTES)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  desc_t          head_i,
  output logic           pop_o,
  output logic           mem_re_o,
  output logic [IDX_W:0] mem_raddr_o,
  input  logic [7:0]     mem_rdata_i,
  scfp_cmd_if.source     out_o
);

  logic      [4:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic            ov_q, ov_d;
  res_info_t       pend_info_q;
  res_info_t       out_info_q;
  logic      [7:0] out_data_q;

  logic      move, issue, last_item;
  res_info_t issue_info;

  assign move      = pend_q && (!ov_q || out_o.ready);
  assign issue     = head_valid_i && (!pend_q || move);
  assign last_item = (head_i.data_cnt == 5'd0) ||
                     (idx_q == head_i.data_cnt - 5'd1);

  assign issue_info.cmd_address     = head_i.address;
  assign issue_info.cmd_data_length = head_i.data_cnt;
  assign issue_info.byte_index      = idx_q;
  assign issue_info.no_data         = (head_i.data_cnt == 5'd0);
  assign issue_info.last            = last_item;

  assign pop_o       = issue && last_item;
  assign mem_re_o    = issue;
  assign mem_raddr_o = {head_i.bank, IDX_W'(idx_q)};

  always_comb begin
    idx_d  = idx_q;
    pend_d = pend_q;
    ov_d   = ov_q;
    if (issue) begin
      idx_d  = last_item ? 5'd0 : idx_q + 5'd1;
      pend_d = 1'b1;
    end else if (move) begin
      pend_d = 1'b0;
    end
    if (move) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 5'd0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_info_q <= issue_info;
    end
    if (move) begin
      out_info_q <= pend_info_q;
      out_data_q <= pend_info_q.no_data ? 8'd0 : mem_rdata_i;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.cmd_address     = out_info_q.cmd_address;
  assign out_o.cmd_data_length = out_info_q.cmd_data_length;
  assign out_o.byte_index      = out_info_q.byte_index;
  assign out_o.cmd_data_byte   = out_data_q;
  assign out_o.last            = out_info_q.last;

endmodule

### design/serial_command_frame_parser.sv
// ----------------------------------------------------------------------------
// serial_command_frame_parser
// Result path: descriptor queue, registered store read, result register.
// Throughput: one byte per cycle in, one result word per cycle out if ready.
//   Bytes stall only while two finished commands wait in the descriptor queue.
// Reset: clears frame progress, queue, output and restores register defaults;
//   the frame store needs no clearing pass.
// ----------------------------------------------------------------------------
module serial_command_frame_parser import scfp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  scfp_byte_if.sink  in_i,
  scfp_cmd_if.source out_o
);

  localparam int unsigned IDX_W = $clog2(BUFFER_BYTES);

  cfg_t           cfg_q;
  logic           push, q_full, head_valid, pop;
  desc_t          desc, head;
  logic           mem_we, mem_re;
  logic [IDX_W:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte    <= HEADER_RST;
      cfg_q.tail_byte      <= TAIL_RST;
      cfg_q.max_data_bytes <= MAX_DATA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER:   cfg_q.header_byte    <= cfg_data_i;
        CFG_TAIL:     cfg_q.tail_byte      <= cfg_data_i;
        CFG_MAX_DATA: cfg_q.max_data_bytes <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  scfp_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .desc_o      (desc),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  scfp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  scfp_ram #(.WIDTH(8), .DEPTH(2 << IDX_W)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  scfp_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .out_o        (out_o)
  );

endmodule

### design/scfp_checker.sv
// ----------------------------------------------------------------------------
// scfp_checker
// Port-level checks on the result channel of the frame parser.
// ----------------------------------------------------------------------------
module scfp_checker import scfp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] cmd_address,
  input logic [4:0] cmd_data_length,
  input logic [4:0] byte_index,
  input logic [7:0] cmd_data_byte,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(cmd_address) &&
      $stable(cmd_data_byte) && $stable(byte_index) && $stable(last))
    else $error("result word changed while stalled");

  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && cmd_data_length == 5'd0 |->
      byte_index == 5'd0 && cmd_data_byte == 8'd0 && last)
    else $error("empty command result malformed");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && cmd_data_length != 5'd0 |->
      last == (byte_index == cmd_data_length - 5'd1))
    else $error("last flag misplaced");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last ##1 out_valid |->
      byte_index == $past(byte_index) + 5'd1 && cmd_address == $past(cmd_address))
    else $error("data run out of order");

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .cmd_address     (out_o.cmd_address),
  .cmd_data_length (out_o.cmd_data_length),
  .byte_index      (out_o.byte_index),
  .cmd_data_byte   (out_o.cmd_data_byte),
  .last            (out_o.last)
);

### sim/tb_serial_command_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_command_frame_parser
// Streams received bytes into the frame parser and checks every command word
// against a cycle-free predictor of the frame rules. Runs several register
// settings and flow-control mixes: directed frames first, then random frames.
// ----------------------------------------------------------------------------
module tb_serial_command_frame_parser;
  import scfp_pkg::*;

  localparam int unsigned BUF_BYTES     = BUFFER_BYTES_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned ERR_PRINTS    = 20;

  typedef struct packed {
    logic [7:0] address;
    logic [4:0] data_cnt;
    logic [4:0] byte_index;
    logic [7:0] data_byte;
    logic       last;
  } cmd_word_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_TYPE,
    FLAW_SUM,
    FLAW_TAIL,
    FLAW_SHORT_LEN,
    FLAW_LONG_LEN,
    FLAW_CUT
  } flaw_e;

  class cmd_scoreboard;
    logic [7:0]  hdr;
    logic [7:0]  tail;
    logic [4:0]  max_data;
    int unsigned fill;
    logic [7:0]  store [BUF_BYTES];
    cmd_word_t   cmd_q [$];
    int unsigned errors;
    int unsigned words_ok;

    function new();
      hdr      = HEADER_RST;
      tail     = TAIL_RST;
      max_data = MAX_DATA_RST;
      fill     = 0;
      errors   = 0;
      words_ok = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] v);
      case (idx)
        CFG_HEADER:   hdr = v;
        CFG_TAIL:     tail = v;
        CFG_MAX_DATA: max_data = v[4:0];
        default: ;
      endcase
    endfunction

    function int unsigned limit();
      return (max_data > RESULT_LIMIT) ? RESULT_LIMIT : max_data;
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned total;
      int unsigned dlen;
      int unsigned i;
      logic [7:0]  sum;
      bit          ok;
      cmd_word_t   w;
      if (fill == 0 && b != hdr) return;
      if (fill >= BUF_BYTES) begin
        fill = 0;
        return;
      end
      store[fill] = b;
      fill++;
      if (fill == 2) begin
        if (b < MIN_LENGTH || int'(b) + 3 > BUF_BYTES) fill = 0;
        return;
      end
      if (fill < 2) return;
      total = int'(store[1]) + 3;
      if (fill < total) return;
      if (fill != total || total > BUF_BYTES) begin
        fill = 0;
        return;
      end
      sum = 8'h00;
      for (i = 1; i < total - 2; i++) sum ^= store[i];
      dlen = int'(store[1]) - 3;
      ok = store[0] == hdr && store[2] == CMD_TYPE && store[total-2] == sum &&
           store[total-1] == tail && dlen <= limit();
      fill = 0;
      if (!ok) return;
      if (dlen == 0) begin
        w = {store[3], 5'd0, 5'd0, 8'h00, 1'b1};
        cmd_q.push_back(w);
      end else begin
        for (i = 0; i < dlen; i++) begin
          w = {store[3], dlen[4:0], i[4:0], store[4+i], (i + 1 == dlen)};
          cmd_q.push_back(w);
        end
      end
    endfunction

    function void field_ok(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        if (errors < ERR_PRINTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(cmd_word_t got);
      cmd_word_t exp_w;
      int unsigned errs_in;
      if (cmd_q.size() == 0) begin
        if (errors < ERR_PRINTS)
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      errs_in = errors;
      exp_w = cmd_q.pop_front();
      field_ok("cmd_address", exp_w.address, got.address);
      field_ok("cmd_data_length", 8'(exp_w.data_cnt), 8'(got.data_cnt));
      field_ok("byte_index", 8'(exp_w.byte_index), 8'(got.byte_index));
      field_ok("cmd_data_byte", exp_w.data_byte, got.data_byte);
      field_ok("last", 8'(exp_w.last), 8'(got.last));
      if (errors == errs_in) words_ok++;
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  scfp_byte_if byte_ch ();
  scfp_cmd_if  cmd_ch ();

  serial_command_frame_parser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (byte_ch),
    .out_o      (cmd_ch)
  );

  cmd_scoreboard sb = new();
  logic [7:0]    frame_q [$];
  int unsigned   src_idle_pct;
  int unsigned   snk_stall_pct;
  int unsigned   stall_cycles;
  int unsigned   frame_bytes;
  int unsigned   frames_sent;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    cmd_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (byte_ch.valid && byte_ch.ready) sb.note_byte(byte_ch.in_byte);
      if (cmd_ch.valid && cmd_ch.ready)
        sb.check_word({cmd_ch.cmd_address, cmd_ch.cmd_data_length, cmd_ch.byte_index,
                       cmd_ch.cmd_data_byte, cmd_ch.last});
      if (cfg_we_i || (byte_ch.valid && byte_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // leaves valid high; callers that pause must lower it
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    byte_ch.valid   = 1'b1;
    byte_ch.in_byte = b;
    do @(posedge clk_i); while (!byte_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i]);
    frame_bytes += frame_q.size();
    frames_sent++;
  endtask

  task automatic build_frame(int unsigned dlen, flaw_e flaw, logic [7:0] addr);
    logic [7:0] sum;
    frame_q = {};
    frame_q.push_back(sb.hdr);
    if (flaw == FLAW_SHORT_LEN) begin
      frame_q.push_back(8'($urandom_range(0, 2)));
      return;
    end
    if (flaw == FLAW_LONG_LEN) begin
      frame_q.push_back(8'($urandom_range(BUF_BYTES - 2, 255)));
      return;
    end
    frame_q.push_back(8'(dlen + 3));
    frame_q.push_back(flaw == FLAW_TYPE ? CMD_TYPE ^ 8'($urandom_range(1, 255)) : CMD_TYPE);
    frame_q.push_back(addr);
    repeat (dlen) frame_q.push_back(8'($urandom_range(0, 255)));
    sum = 8'h00;
    for (int i = 1; i < frame_q.size(); i++) sum ^= frame_q[i];
    frame_q.push_back(flaw == FLAW_SUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
    frame_q.push_back(flaw == FLAW_TAIL ? sb.tail ^ 8'($urandom_range(1, 255)) : sb.tail);
    if (flaw == FLAW_CUT) frame_q = frame_q[0 : $urandom_range(2, frame_q.size() - 2)];
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] v);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = v;
    @(negedge clk_i);
  endtask

  task automatic configure(logic [7:0] h, logic [7:0] t, logic [4:0] m);
    write_reg(CFG_HEADER, h);
    write_reg(CFG_TAIL, t);
    write_reg(CFG_MAX_DATA, {3'b000, m});
    cfg_we_i = 1'b0;
  endtask

  task automatic settle();
    byte_ch.valid = 1'b0;
    while (sb.cmd_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_traffic(int unsigned nbytes);
    int unsigned start;
    int unsigned r;
    int unsigned lim;
    int unsigned dlen;
    flaw_e       flaw;
    start = frame_bytes;
    while (frame_bytes - start < nbytes) begin
      lim = sb.limit();
      r = $urandom_range(99);
      if (r < 70) dlen = $urandom_range(0, (lim < 6) ? lim : 6);
      else if (r < 85) dlen = $urandom_range(0, RESULT_LIMIT);
      else dlen = $urandom_range(lim, (lim + 2 < RESULT_LIMIT) ? lim + 2 : RESULT_LIMIT);
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        continue;
      end
      flaw = (r < 14) ? FLAW_CUT : (r < 20) ? FLAW_TYPE : (r < 26) ? FLAW_SUM :
             (r < 32) ? FLAW_TAIL : (r < 36) ? FLAW_SHORT_LEN :
             (r < 40) ? FLAW_LONG_LEN : FLAW_NONE;
      build_frame(dlen, flaw, 8'($urandom_range(0, 255)));
      send_frame();
    end
  endtask

  initial begin
    logic [7:0] split_q [$];
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_HEADER;
    cfg_data_i      = 8'h00;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = 8'h00;
    cmd_ch.ready    = 1'b0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    stall_cycles    = 0;
    frame_bytes     = 0;
    frames_sent     = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    configure(HEADER_RST, TAIL_RST, MAX_DATA_RST);
    // stray bytes, short length, oversized length
    frame_q = '{8'h00, 8'hFF, HEADER_RST, 8'h02, HEADER_RST, 8'h1E};
    send_frame();
    build_frame(0, FLAW_NONE, 8'hFF);
    send_frame();
    build_frame(1, FLAW_NONE, 8'h00);
    send_frame();
    build_frame(0, FLAW_TYPE, 8'h5A);
    send_frame();
    build_frame(0, FLAW_SUM, 8'hA5);
    send_frame();
    build_frame(0, FLAW_TAIL, 8'h3C);
    send_frame();
    build_frame(RESULT_LIMIT, FLAW_NONE, 8'($urandom_range(0, 255)));
    send_frame();
    random_traffic(56);
    settle();

    // header register changes while a frame is half received
    build_frame(1, FLAW_NONE, 8'($urandom_range(0, 255)));
    split_q = frame_q;
    frame_q = split_q[0:3];
    send_frame();
    settle();
    configure(8'h00, 8'hFF, 5'd31);
    frame_q = '{split_q[4], split_q[5], sb.tail};
    send_frame();
    src_idle_pct = 71;
    random_traffic(56);
    settle();

    configure(8'hFF, 8'h00, 5'd0);
    src_idle_pct  = 0;
    snk_stall_pct = 71;
    random_traffic(28);
    settle();
    random_traffic(28);
    settle();

    configure(8'h5A, 8'hA5, 5'd5);
    src_idle_pct  = 35;
    snk_stall_pct = 35;
    random_traffic(56);
    settle();

    $display("Sent %0d frames (%0d frame bytes), checked %0d command words,",
             frames_sent, frame_bytes, sb.words_ok);
    $display("over four register settings and four flow-control mixes.");
    if (sb.errors == 0 && sb.cmd_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d words never seen", sb.errors, sb.cmd_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### serial_command_frame_parser.f
design/scfp_pkg.sv
design/scfp_byte_if.sv
design/scfp_cmd_if.sv
design/scfp_ram.sv
design/scfp_front.sv
design/scfp_cmd_fifo.sv
design/scfp_back.sv
design/serial_command_frame_parser.sv
design/scfp_checker.sv
sim/tb_serial_command_frame_parser.sv
